@@ sv/stereogram_row_shifter_macros.svh @@
// Assertion macros shared by the stereogram row shifter modules.
`ifndef STEREOGRAM_ROW_SHIFTER_MACROS_SVH
`define STEREOGRAM_ROW_SHIFTER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define SRS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ sv/srs_pkg.sv @@
// Shared types and constants of the stereogram row shifter.
package srs_pkg;

  // Field widths fixed by the stream format
  localparam int DEPTH_W = 8;
  localparam int SHIFT_W = 10;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int DEPTH_LEVELS_DEF = 256;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DEPTH_W-1:0] LOWEST_RESET     = 8'd255;
  localparam logic [CFG_W-1:0]   LINE_WIDTH_RESET = 11'd1024;

  // Item kinds
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } srs_op_t;

  // Per-pixel attributes handed from front to back
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [PIX_W-1:0]   noise;
    logic [DEPTH_W-1:0] min_depth;
    logic               last;
  } srs_attr_t;

endpackage

@@ sv/srs_front.sv @@
// Front end: item accept, column and minimum tracking, shift table.
`include "stereogram_row_shifter_macros.svh"

module srs_front #(
  parameter int MAX_WIDTH    = srs_pkg::MAX_WIDTH_DEF,
  parameter int DEPTH_LEVELS = srs_pkg::DEPTH_LEVELS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [srs_pkg::CFG_W-1:0]               cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  srs_pkg::srs_op_t                        in_op,
  input  logic [srs_pkg::DEPTH_W-1:0]             in_depth,
  input  logic [srs_pkg::SHIFT_W-1:0]             in_shift,
  input  logic [srs_pkg::PIX_W-1:0]               in_noise,
  input  logic                                    in_fstart,
  input  logic [$clog2(srs_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                                    push,
  output logic [$clog2(MAX_WIDTH)-1:0]            push_col,
  output srs_pkg::srs_attr_t                      push_attr
);
  import srs_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int AW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int DW   = $clog2(DEPTH_LEVELS);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_W-1:0]   width_r;
  logic [AW-1:0]      width_ext;
  logic [CW:0]        act_w;
  logic               acc;
  logic               is_pix;
  logic               in_range;
  logic [CW-1:0]      col_base;
  logic [CW-1:0]      col_cur;
  logic               last_cur;
  logic [DEPTH_W-1:0] low_base;
  logic [DEPTH_W-1:0] low_cur;

  logic [CW-1:0]      column_r, column_nxt;
  logic [DEPTH_W-1:0] lowest_r;
  logic               f1_valid_r;
  logic [CW-1:0]      f1_col_r;
  logic [PIX_W-1:0]   f1_noise_r;
  logic [DEPTH_W-1:0] f1_min_r;
  logic               f1_last_r;
  logic               f1_inrange_r;
  logic [SHIFT_W-1:0] tab_rd_r;

  logic [SHIFT_W-1:0] shift_mem [DEPTH_LEVELS];

  // Line width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  // Clamp width into 1..MAX_WIDTH
  assign width_ext = AW'(width_r);
  always_comb begin
    if (width_ext == '0) begin
      act_w = (CW + 1)'(1);
    end else if (width_ext > AW'(MAX_WIDTH)) begin
      act_w = (CW + 1)'(MAX_WIDTH);
    end else begin
      act_w = width_ext[CW:0];
    end
  end

  // Room for this beat and the one already in flight
  assign in_ready = ((QC_W + 1)'(q_count) + (QC_W + 1)'(f1_valid_r))
                    < (QC_W + 1)'(QUEUE_DEPTH);
  assign acc      = in_valid && in_ready;
  assign is_pix   = (in_op == OP_PIXEL);
  assign in_range = {1'b0, in_depth} < (DEPTH_W + 1)'(DEPTH_LEVELS);

  // Column position: frame start and width shrink restart the row
  always_comb begin
    col_base   = in_fstart ? '0 : column_r;
    col_cur    = ({1'b0, col_base} >= act_w) ? '0 : col_base;
    last_cur   = ({1'b0, col_cur} == act_w - (CW + 1)'(1));
    column_nxt = last_cur ? '0 : col_cur + CW'(1);
  end

  // Smallest nonzero depth in the frame
  always_comb begin
    low_base = in_fstart ? LOWEST_RESET : lowest_r;
    low_cur  = (in_depth != '0 && in_depth < low_base) ? in_depth : low_base;
  end

  // Shift table: in-range loads write, pixels read with a registered port
  always_ff @(posedge clk) begin
    if (acc && !is_pix && in_range) begin
      shift_mem[in_depth[DW-1:0]] <= in_shift;
    end
    if (acc && is_pix) begin
      tab_rd_r <= shift_mem[in_depth[DW-1:0]];
    end
  end

  // Row state and stage toward the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      lowest_r   <= LOWEST_RESET;
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= acc && is_pix;
      if (acc && is_pix) begin
        column_r <= column_nxt;
        lowest_r <= low_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_pix) begin
      f1_col_r     <= col_cur;
      f1_noise_r   <= in_noise;
      f1_min_r     <= low_cur;
      f1_last_r    <= last_cur;
      f1_inrange_r <= in_range;
    end
  end

  assign push                = f1_valid_r;
  assign push_col            = f1_col_r;
  assign push_attr.shift     = f1_inrange_r ? tab_rd_r : '0;
  assign push_attr.noise     = f1_noise_r;
  assign push_attr.min_depth = f1_min_r;
  assign push_attr.last      = f1_last_r;

  `SRS_ASSERT_IMP(a_col_in_row, f1_valid_r, {1'b0, f1_col_r} < act_w, "column past line width")

endmodule

@@ sv/srs_queue.sv @@
// Short FIFO between the front and back ends.
`include "stereogram_row_shifter_macros.svh"

module srs_queue #(
  parameter int W = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  logic [W-1:0]                              push_data,
  input  logic                                      pop,
  output logic                                      head_valid,
  output logic [W-1:0]                              head_data,
  output logic [$clog2(srs_pkg::QUEUE_DEPTH+1)-1:0] count
);
  import srs_pkg::*;

  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]    slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] count_r;

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QC_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign count      = count_r;

  `SRS_ASSERT_NEVER(a_no_overflow, push && !pop && count_r == QC_W'(QUEUE_DEPTH), "queue overflow")
  `SRS_ASSERT_IMP(a_no_underflow, pop, count_r != '0, "pop from empty queue")

endmodule

@@ sv/srs_back.sv @@
// Back end: source column decision, line store, output register.
`include "stereogram_row_shifter_macros.svh"

module srs_back #(
  parameter int MAX_WIDTH = srs_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]  head_col,
  input  srs_pkg::srs_attr_t            head_attr,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srs_pkg::PIX_W-1:0]     out_pixel,
  output logic [srs_pkg::DEPTH_W-1:0]   out_min,
  output logic                          out_last
);
  import srs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = ((CW > SHIFT_W) ? CW : SHIFT_W) + 2;

  logic                 adv;
  logic [CW-1:0]        prev_eff;
  logic signed [SW-1:0] src;
  logic signed [SW-1:0] prev_s;
  logic                 b0_noise;
  logic [CW-1:0]        rd_addr;
  logic                 b0_hit;
  logic                 b0_zero;
  logic [PIX_W-1:0]     b1_pix;

  logic [CW-1:0]        prev_r, prev_nxt;
  logic [CW:0]          fill_r;
  logic                 b1_valid_r;
  logic [CW-1:0]        b1_col_r;
  logic [PIX_W-1:0]     b1_noise_pix_r;
  logic                 b1_noise_r;
  logic                 b1_zero_r;
  logic                 b1_hit_r;
  logic [PIX_W-1:0]     b1_fwd_r;
  logic [DEPTH_W-1:0]   b1_min_r;
  logic                 b1_last_r;
  logic [PIX_W-1:0]     rd_r;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_pixel_r;
  logic [DEPTH_W-1:0]   out_min_r;
  logic                 out_last_r;

  logic [PIX_W-1:0]     line_mem [MAX_WIDTH];

  // Whole back end moves when the output register can take a beat
  assign adv = !out_valid_r || out_ready;
  assign pop = head_valid && adv;

  // Source column and copy decision; row start implies previous source 0
  always_comb begin
    prev_eff = (head_col == '0) ? '0 : prev_r;
    src      = $signed(SW'(head_col)) - $signed(SW'(head_attr.shift));
    prev_s   = $signed(SW'(prev_eff));
    b0_noise = (src < prev_s) || (src <= 0);
    if (src < prev_s) begin
      prev_nxt = prev_eff;
    end else if (src <= 0) begin
      prev_nxt = '0;
    end else begin
      prev_nxt = src[CW-1:0];
    end
    rd_addr = src[CW-1:0];
    // Pixel written by the beat ahead lands this edge: forward it
    b0_hit  = b1_valid_r && (b1_col_r == rd_addr);
    // Columns never written since reset read as zero
    b0_zero = ({1'b0, rd_addr} >= fill_r) && !b0_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (pop) begin
      prev_r <= prev_nxt;
    end
  end

  // Final pixel of the beat in the second stage
  always_comb begin
    if (b1_noise_r) begin
      b1_pix = b1_noise_pix_r;
    end else if (b1_zero_r) begin
      b1_pix = '0;
    end else if (b1_hit_r) begin
      b1_pix = b1_fwd_r;
    end else begin
      b1_pix = rd_r;
    end
  end

  // Line store: read at source, write at column, old data on collision
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= line_mem[rd_addr];
      if (b1_valid_r) begin
        line_mem[b1_col_r] <= b1_pix;
      end
    end
  end

  // Written prefix of the line store and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r  <= head_valid;
      out_valid_r <= b1_valid_r;
      if (b1_valid_r && ({1'b0, b1_col_r} == fill_r)) begin
        fill_r <= fill_r + (CW + 1)'(1);
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_col_r       <= head_col;
      b1_noise_pix_r <= head_attr.noise;
      b1_noise_r     <= b0_noise;
      b1_zero_r      <= b0_zero;
      b1_hit_r       <= b0_hit;
      b1_fwd_r       <= b1_pix;
      b1_min_r       <= head_attr.min_depth;
      b1_last_r      <= head_attr.last;
      if (b1_valid_r) begin
        out_pixel_r <= b1_pix;
        out_min_r   <= b1_min_r;
        out_last_r  <= b1_last_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_min   = out_min_r;
  assign out_last  = out_last_r;

  `SRS_ASSERT_IMP(a_src_behind_col, pop && !b0_noise, (src > 0) && (rd_addr <= head_col), "copy source ahead of column")

endmodule

@@ sv/stereogram_row_shifter.sv @@
// Usage notes:
// Random-dot stereogram row generator. Input beats on in_* carry either a
// shift table load (in_tuser[0] = 0) or a pixel (in_tuser[0] = 1); a load
// gives no output beat, a pixel gives exactly one on out_*.
// in_tdata: depth index, shift value, noise pixel; in_tuser[1] marks the
// first pixel of a frame. out_tdata: pixel, minimum depth; out_tlast marks
// the last column of a row. cfg_we/cfg_wdata set the line width; write it
// only while no pixel is in flight.
// Throughput: one item per clock unless out_tready stalls, set by the single
// line store port pair (one read at the source, one write at the column).
// Path: an accepted pixel passes the shift table read, the queue, the line
// store read with forwarding and the output register before out_tvalid.
// Reset (rst_n low, synchronous): line width 1024, column 0, minimum 255,
// line store reads as zero until written; no clearing pass is needed.
// The shift table holds nothing until loaded.
// When the receiver stalls the output register holds its beat, the back
// end freezes, the four-entry queue fills and in_tready falls; nothing is
// dropped and in_tready returns once the queue has room again.
module stereogram_row_shifter #(
  parameter int MAX_WIDTH    = srs_pkg::MAX_WIDTH_DEF,
  parameter int DEPTH_LEVELS = srs_pkg::DEPTH_LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [srs_pkg::CFG_W-1:0] cfg_wdata,  // line_width
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // depth_index, shift_value, noise_pixel
  input  logic [1:0]                in_tuser,   // operation, frame_start
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // out_pixel, min_depth_index
  output logic                      out_tlast
);
  import srs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AB = $bits(srs_attr_t);
  localparam int QW = CW + AB;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  logic              push;
  logic [CW-1:0]     push_col;
  srs_attr_t         push_attr;
  logic              pop;
  logic              head_valid;
  logic [QW-1:0]     head_data;
  logic [QC_W-1:0]   q_count;
  logic [PIX_W-1:0]  pix;
  logic [DEPTH_W-1:0] min_d;

  srs_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .DEPTH_LEVELS (DEPTH_LEVELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (srs_op_t'(in_tuser[0])),
    .in_depth  (in_tdata[7:0]),
    .in_shift  (in_tdata[17:8]),
    .in_noise  (in_tdata[25:18]),
    .in_fstart (in_tuser[1]),
    .q_count   (q_count),
    .push      (push),
    .push_col  (push_col),
    .push_attr (push_attr)
  );

  srs_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_col, push_attr}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  srs_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_col   (head_data[QW-1 -: CW]),
    .head_attr  (srs_attr_t'(head_data[AB-1:0])),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pixel  (pix),
    .out_min    (min_d),
    .out_last   (out_tlast)
  );

  assign out_tdata = {min_d, pix};

endmodule
